>>> rtl/fsls_pkg.sv
// Shared constants and types for the fixed-string line search block.
package fsls_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int LEN_CAP     = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
    localparam int IDX_W       = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;

    localparam int BYTE_W  = 8;
    localparam int FILE_W  = 16;
    localparam int LINE_W  = 24;
    localparam int COL_W   = 16;
    localparam int LEN_W   = 5;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] NEWLINE  = 8'd10;
    localparam logic [LINE_W-1:0] LINE_SAT = {LINE_W{1'b1}};
    localparam logic [COL_W-1:0]  COL_SAT  = {COL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 2'd2;

    typedef logic [BYTE_W-1:0]             byte_t;
    typedef logic [LEN_CAP-1:0][BYTE_W-1:0] win_t;
    typedef logic [IDX_W-1:0]              idx_t;

endpackage

>>> rtl/fixed_string_line_search.sv
// Top level of the fixed-string line search: stream in text, report the first match per line.
//
// Text bytes stream in one per transfer on the s_axis side; s_axis_tuser
// flags the first byte of a new file. Each byte is compared, together with
// the bytes before it, against a pattern of 1 to 16 bytes set through the
// cfg port (pattern_lo at index 0, pattern_hi at index 1, pattern_len at
// index 2; a length of 0 acts as 1, above 16 as 16). The first match in a
// line gives one result transfer carrying file number (from 0), line
// (from 1) and start column (from 1); later matches in that line are
// dropped until a newline (byte 10) arrives. Carriage return is ordinary
// text. Line and column counters saturate; the file counter wraps and
// starts at all ones so the first file start yields file 0. The block
// takes one byte per cycle while no result is held by a low m_axis_tready:
// a transfer loads the input register, and while the byte sits there the
// window compare and counter update run and, as it moves on, load the
// result register, from which the result is offered. A result held by a low
// m_axis_tready holds the input register and with it s_axis_tready.
// Write the configuration only while no byte is in flight.
module fixed_string_line_search (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // input stream
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  logic [7:0]                                   s_axis_tdata,  // [7:0] text_byte
    input  logic                                         s_axis_tuser,  // [0] file_start
    // result stream
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // [15:0] file_number, [39:16] line_number, [55:40] start_column
    output logic [55:0]                                  m_axis_tdata,
    // configuration writes
    input  logic                                         cfg_we,
    input  logic [fsls_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [fsls_pkg::CFG_W-1:0]                   cfg_data
);
    import fsls_pkg::*;

    // configuration
    logic [CFG_W-1:0] pattern_lo_reg;
    logic [CFG_W-1:0] pattern_hi_reg;
    logic [LEN_W-1:0] pattern_len_reg;

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;
    logic  in_fs_reg;

    // search state
    win_t             window_reg;
    logic [LINE_W-1:0] line_reg;
    logic [COL_W-1:0]  col_reg;
    logic              skip_reg;
    logic [FILE_W-1:0] file_reg;

    // result register
    logic              m_valid_reg;
    logic [FILE_W-1:0] m_file_reg;
    logic [LINE_W-1:0] m_line_reg;
    logic [COL_W-1:0]  m_col_reg;

    // datapath
    logic              advance;
    logic              work;
    win_t              window_next;
    win_t              pattern;
    idx_t              len_m1;
    logic              hit;
    logic              is_newline;
    logic              found;
    logic [FILE_W-1:0] file_eff;
    logic [LINE_W-1:0] line_eff;
    logic [COL_W-1:0]  col_eff;
    logic              skip_eff;
    logic [COL_W-1:0]  start_col;
    logic [LINE_W-1:0] line_next;
    logic [COL_W-1:0]  col_next;
    logic              skip_next;

    // Move the pipeline whenever the result register is free or being taken.
    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign work          = in_valid_reg && advance;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_col_reg, m_line_reg, m_file_reg};

    // Clamp the length to 1..LEN_CAP and keep it as length minus one.
    always_comb begin
        if (pattern_len_reg == '0) begin
            len_m1 = '0;
        end else if (pattern_len_reg > LEN_W'(LEN_CAP)) begin
            len_m1 = IDX_W'(LEN_CAP - 1);
        end else begin
            len_m1 = IDX_W'(pattern_len_reg - LEN_W'(1));
        end
    end

    assign pattern = win_t'({pattern_hi_reg, pattern_lo_reg});

    // Shift the new byte into the window, newest first.
    always_comb begin
        window_next[0] = in_byte_reg;
        for (int i = 1; i < LEN_CAP; i++) begin
            window_next[i] = window_reg[i-1];
        end
    end

    fsls_match u_match (
        .window  (window_next),
        .pattern (pattern),
        .len_m1  (len_m1),
        .hit     (hit)
    );

    // A file start restarts the counters before this byte is counted.
    always_comb begin
        if (in_fs_reg) begin
            file_eff = file_reg + FILE_W'(1);
            line_eff = LINE_W'(1);
            col_eff  = '0;
            skip_eff = 1'b0;
        end else begin
            file_eff = file_reg;
            line_eff = line_reg;
            col_eff  = col_reg;
            skip_eff = skip_reg;
        end
    end

    assign is_newline = (in_byte_reg == NEWLINE);
    // Enough bytes of this line must be in the window for a full match.
    assign found = !is_newline && !skip_eff && hit && (col_eff >= COL_W'(len_m1));
    // col_eff + 2 - len = col_eff + 1 - len_m1; stick at the top once saturated.
    assign start_col = (col_eff == COL_SAT) ? COL_SAT
                                            : col_eff + COL_W'(1) - COL_W'(len_m1);

    always_comb begin
        if (is_newline) begin
            line_next = (line_eff == LINE_SAT) ? line_eff : line_eff + LINE_W'(1);
            col_next  = '0;
            skip_next = 1'b0;
        end else begin
            line_next = line_eff;
            col_next  = (col_eff == COL_SAT) ? col_eff : col_eff + COL_W'(1);
            skip_next = skip_eff || found;
        end
    end

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_lo_reg  <= '0;
            pattern_hi_reg  <= '0;
            pattern_len_reg <= LEN_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PATTERN_LO:  pattern_lo_reg  <= cfg_data;
                REG_PATTERN_HI:  pattern_hi_reg  <= cfg_data;
                REG_PATTERN_LEN: pattern_len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the byte until the compare stage takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_fs_reg   <= s_axis_tuser;
        end
    end

    // Search state: advance once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= LINE_W'(1);
            col_reg  <= '0;
            skip_reg <= 1'b0;
            file_reg <= '1;
        end else if (work) begin
            line_reg <= line_next;
            col_reg  <= col_next;
            skip_reg <= skip_next;
            file_reg <= file_eff;
        end
        if (work) begin
            window_reg <= window_next;
        end
    end

    // Result register: load a hit, drop the valid once the transfer is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= work && found;
        end
        if (work && found) begin
            m_file_reg <= file_eff;
            m_line_reg <= line_eff;
            m_col_reg  <= start_col;
        end
    end

endmodule

>>> rtl/fsls_match.sv
// Parallel compare of the byte window against the configured pattern.
module fsls_match (
    input  fsls_pkg::win_t window,   // newest byte at index 0
    input  fsls_pkg::win_t pattern,  // first pattern byte at index 0
    input  fsls_pkg::idx_t len_m1,   // pattern length minus one
    output logic           hit
);
    import fsls_pkg::*;

    logic [LEN_CAP-1:0] lane_ok;
    idx_t               pidx [LEN_CAP];

    // Window byte j pairs with pattern byte len-1-j; lanes past the length pass.
    always_comb begin
        for (int j = 0; j < LEN_CAP; j++) begin
            pidx[j] = len_m1 - IDX_W'(j);
            if (IDX_W'(j) > len_m1) begin
                lane_ok[j] = 1'b1;
            end else begin
                lane_ok[j] = (window[j] == pattern[pidx[j]]);
            end
        end
    end

    assign hit = &lane_ok;

endmodule
